// ===== hdl/cps_pkg.sv =====
// Shared types and constants for the class pattern search core.
package cps_pkg;

    // Selector carried in s_tuser
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_END  = 2'd2
    } cps_kind_t;

    // Element class codes
    typedef enum logic [1:0] {
        CLS_LIT   = 2'd0,
        CLS_UPPER = 2'd1,
        CLS_DIGIT = 2'd2
    } cps_class_t;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    localparam int LEN_W   = 5;
    localparam int MATCH_W = 16;

    // One pattern element
    typedef struct packed {
        logic       repeat_en;
        logic [1:0] cls;
        logic [7:0] lit;
    } cps_elem_t;

    // Per-cell strobes
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } cps_cell_ctrl_t;

    // One result beat
    typedef struct packed {
        logic               too_long;
        logic               found;
        logic [MATCH_W-1:0] match_start;
    } cps_result_t;

endpackage

// ===== hdl/cps_cell.sv =====
// One pattern element cell: element entry, active bit and earliest start.
module cps_cell
    import cps_pkg::*;
#(
    parameter int POS_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cps_cell_ctrl_t   ctrl,
    input  cps_elem_t        load_elem,
    input  logic [7:0]       text_byte,
    input  logic             prev_active,
    input  logic [POS_W-1:0] prev_start,
    output logic             active_q,
    output logic [POS_W-1:0] start_q,
    output logic             active_next,
    output logic [POS_W-1:0] start_next
);

    cps_elem_t        elem_reg;
    logic             active_reg;
    logic [POS_W-1:0] start_reg;
    logic             accepts;
    logic             chain_ok;
    logic             self_ok;
    logic [POS_W-1:0] cand_start;

    always_comb begin
        case (elem_reg.cls)
            CLS_LIT:   accepts = (text_byte == elem_reg.lit);
            CLS_UPPER: accepts = text_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
            CLS_DIGIT: accepts = text_byte inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]};
            default:   accepts = 1'b0;
        endcase
    end

    // Extend from the left neighbor, or stay on this element when it repeats
    always_comb begin
        chain_ok = accepts && prev_active;
        self_ok  = accepts && elem_reg.repeat_en && active_reg;
        if (chain_ok && self_ok) begin
            cand_start = (start_reg < prev_start) ? start_reg : prev_start;
        end else if (self_ok) begin
            cand_start = start_reg;
        end else begin
            cand_start = prev_start;
        end
        active_next = chain_ok || self_ok;
        start_next  = active_next ? cand_start : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            elem_reg <= load_elem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end else if (ctrl.step) begin
            active_reg <= active_next;
            start_reg  <= start_next;
        end
    end

    assign active_q = active_reg;
    assign start_q  = start_reg;

endmodule

// ===== hdl/cps_out_stage.sv =====
// Output register with skid slot for result beats.
module cps_out_stage
    import cps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  cps_result_t in_data,
    output logic        in_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output cps_result_t m_data
);

    logic        out_valid_reg;
    logic        out_valid_next;
    cps_result_t out_data_reg;
    cps_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    cps_result_t skid_data_reg;
    cps_result_t skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            // Drain the skid slot first, else take the new beat
            out_valid_next  = skid_valid_reg || in_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

endmodule

// ===== hdl/class_pattern_search_core.sv =====
// Top level of the class pattern search core: element cell chain and result path.
//
// Usage: load up to PATTERN_MAX elements on the slave stream (s_tuser = load),
// set the element count on the cfg channel, then stream text bytes one per beat
// (s_tuser = byte) and close each string with an end beat (s_tuser = end).
// Each end beat yields one result beat on the master stream: found, the
// earliest match start and a too-long flag; the search state is then cleared
// and the pattern kept. Load and byte beats produce no result.
// Throughput: one input beat per cycle while s_tready is high. Every byte
// updates the whole chain of element cells at once, each cell looking only at
// its left neighbor, so the per-byte path is one cell plus the tail select
// and the best-start compare.
// Result path: the end beat's result is registered in the output register, or
// in the skid slot while that register is stalled. Stall: when m_tready is low
// the result holds in the output register; one more result fits in a skid
// slot, and s_tready drops only while that slot is full.
// Reset (aresetn low, synchronous): clears the search state, the result
// path and the element count (length 0); the element entries are not cleared
// and must be loaded before use. cfg writes are accepted at any time.
module class_pattern_search_core
    import cps_pkg::*;
#(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] elem_index, [5:4] elem_class, [13:6] elem_byte, [14] elem_repeat,
    // [22:15] text_byte, [23] zero
    input  logic [23:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    // Master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] match_start
    output logic [15:0] m_tdata,
    // [0] found, [1] too_long
    output logic [1:0]  m_tuser,
    // Configuration: pattern_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int POS_W = POSITION_BITS;

    // Decoded beat
    logic             s_accept;
    cps_kind_t        kind;
    logic [3:0]       elem_index;
    cps_elem_t        load_elem;
    logic [7:0]       text_byte;

    // Search state
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             best_found_reg;
    logic             best_found_next;
    logic [POS_W-1:0] best_start_reg;
    logic [POS_W-1:0] best_start_next;

    // Tail select from the element count
    logic [PATTERN_MAX-1:0] tail_reg;
    logic [PATTERN_MAX-1:0] tail_next;
    logic                   empty_reg;
    logic                   empty_next;

    // Cell chain
    cps_cell_ctrl_t   cell_ctrl [PATTERN_MAX];
    logic             act_q     [PATTERN_MAX];
    logic [POS_W-1:0] start_q   [PATTERN_MAX];
    logic             act_n     [PATTERN_MAX];
    logic [POS_W-1:0] start_n   [PATTERN_MAX];

    logic             at_max;
    logic             byte_step;
    logic             end_beat;
    logic             tail_hit;
    logic [POS_W-1:0] tail_start;
    logic             cand_found;
    logic [POS_W-1:0] cand_start;

    cps_result_t      result;
    cps_result_t      m_result;

    assign s_accept   = s_tvalid && s_tready;
    assign kind       = cps_kind_t'(s_tuser);
    assign elem_index = s_tdata[3:0];
    assign load_elem  = '{repeat_en: s_tdata[14], cls: s_tdata[5:4], lit: s_tdata[13:6]};
    assign text_byte  = s_tdata[22:15];

    // A byte that finds the position counter full is counted as overflow only
    assign at_max    = (pos_reg == {POS_W{1'b1}});
    assign byte_step = s_accept && (kind == KIND_BYTE) && !at_max;
    assign end_beat  = s_accept && (kind == KIND_END);

    // Per-cell strobes; a load index beyond the chain hits no cell
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            cell_ctrl[k].load  = s_accept && (kind == KIND_LOAD) && (int'(elem_index) == k);
            cell_ctrl[k].step  = byte_step;
            cell_ctrl[k].clear = end_beat;
        end
    end

    // Cell 0 sees an always-active left neighbor that starts at the current position
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        if (k == 0) begin : g_head
            cps_cell #(.POS_W(POS_W)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[k]),
                .load_elem  (load_elem),
                .text_byte  (text_byte),
                .prev_active(1'b1),
                .prev_start (pos_reg),
                .active_q   (act_q[k]),
                .start_q    (start_q[k]),
                .active_next(act_n[k]),
                .start_next (start_n[k])
            );
        end else begin : g_body
            cps_cell #(.POS_W(POS_W)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[k]),
                .load_elem  (load_elem),
                .text_byte  (text_byte),
                .prev_active(act_q[k-1]),
                .prev_start (start_q[k-1]),
                .active_q   (act_q[k]),
                .start_q    (start_q[k]),
                .active_next(act_n[k]),
                .start_next (start_n[k])
            );
        end
    end

    // Pick the completion from the last element in use (one-hot select)
    always_comb begin
        tail_hit   = 1'b0;
        tail_start = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            tail_hit   = tail_hit | (tail_reg[k] & act_n[k]);
            tail_start = tail_start | (start_n[k] & {POS_W{tail_reg[k] & act_n[k]}});
        end
        cand_found = empty_reg || tail_hit;
        cand_start = empty_reg ? '0 : tail_start;
    end

    // Element count: clamp to the chain length, keep as one-hot tail plus empty flag
    always_comb begin
        tail_next  = tail_reg;
        empty_next = empty_reg;
        if (cfg_valid) begin
            empty_next = (cfg_data == '0);
            for (int k = 0; k < PATTERN_MAX; k++) begin
                tail_next[k] = (int'(cfg_data) == k + 1) ||
                               ((k == PATTERN_MAX - 1) && (int'(cfg_data) > PATTERN_MAX));
            end
        end
    end

    always_comb begin
        pos_next        = pos_reg;
        overflow_next   = overflow_reg;
        best_found_next = best_found_reg;
        best_start_next = best_start_reg;
        if (s_accept) begin
            case (kind)
                KIND_BYTE: begin
                    if (at_max) begin
                        overflow_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                        // An empty pattern only claims position 0 when nothing is found yet
                        if (cand_found && (!best_found_reg ||
                                           (!empty_reg && cand_start < best_start_reg))) begin
                            best_found_next = 1'b1;
                            best_start_next = cand_start;
                        end
                    end
                end
                KIND_END: begin
                    pos_next        = '0;
                    overflow_next   = 1'b0;
                    best_found_next = 1'b0;
                    best_start_next = '0;
                end
                default: begin
                    // Load beats touch only the cells; unknown kinds are dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            overflow_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            best_start_reg <= '0;
            tail_reg       <= '0;
            empty_reg      <= 1'b1;
        end else begin
            pos_reg        <= pos_next;
            overflow_reg   <= overflow_next;
            best_found_reg <= best_found_next;
            best_start_reg <= best_start_next;
            tail_reg       <= tail_next;
            empty_reg      <= empty_next;
        end
    end

    // Result of the string being closed
    always_comb begin
        result.too_long    = overflow_reg;
        result.found       = !overflow_reg && best_found_reg;
        result.match_start = result.found ? MATCH_W'(best_start_reg) : '0;
    end

    cps_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(end_beat),
        .in_data (result),
        .in_ready(s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_result)
    );

    assign m_tdata   = m_result.match_start;
    assign m_tuser   = {m_result.too_long, m_result.found};
    assign cfg_ready = 1'b1;

endmodule

// ===== hdl/cps_checker.sv =====
// Port-level checks for the class pattern search core, bound to the top level.
module cps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // Too-long results carry no match
    a_too_long_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == '0))
        else $error("too-long result carries a match");

    // Not-found results carry a zero start
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("not-found result with nonzero start");

    // Input backpressure only follows a stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("s_tready low without output stall");

endmodule

bind class_pattern_search_core cps_checker u_cps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
